FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file in rtl/ imports this package.
package spq_pkg;

    localparam int SPQ_DEPTH = 16;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] removed_value;
        logic [4:0]         fill_count;
    } t_rsp;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NOP,
        DP_REJECT,
        DP_ENQ_FIRST,
        DP_SCAN_START,
        DP_SHIFT,
        DP_PLACE,
        DP_DEQ_READ,
        DP_DEQ_POP
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status reject_status;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic greater;
        logic idx_zero;
    } t_dp_sts;

endpackage

FILE: rtl/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives commands into spq_datapath.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_opcode i_opcode,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENQ_CMP,
        S_ENQ_PLACE,
        S_DEQ_POP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state           = r_state;
        o_cmd.op          = DP_NOP;
        o_cmd.reject_status = ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_start && !r_busy) begin
                    if (i_opcode == OP_DEQ) begin
                        if (i_sts.empty) begin
                            o_cmd.op            = DP_REJECT;
                            o_cmd.reject_status = ST_EMPTY;
                        end else begin
                            o_cmd.op = DP_DEQ_READ;
                            n_state  = S_DEQ_POP;
                        end
                    end else begin
                        if (i_sts.full) begin
                            o_cmd.op            = DP_REJECT;
                            o_cmd.reject_status = ST_FULL;
                        end else if (i_sts.empty) begin
                            o_cmd.op = DP_ENQ_FIRST;
                        end else begin
                            o_cmd.op = DP_SCAN_START;
                            n_state  = S_ENQ_CMP;
                        end
                    end
                end
            end
            S_ENQ_CMP: begin
                // walk down from the tail, shifting larger keys up one slot
                if (i_sts.greater) begin
                    o_cmd.op = DP_SHIFT;
                    if (i_sts.idx_zero) begin
                        n_state = S_ENQ_PLACE;
                    end
                end else begin
                    o_cmd.op = DP_PLACE;
                    n_state  = S_IDLE;
                end
            end
            S_ENQ_PLACE: begin
                o_cmd.op = DP_PLACE;
                n_state  = S_IDLE;
            end
            S_DEQ_POP: begin
                o_cmd.op = DP_DEQ_POP;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: rtl/spq_datapath.sv
// Datapath of the sorted priority queue: key memory as a ring, head, count,
// scan index and result register. Depends on spq_pkg; driven by spq_ctrl.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_value,
    output t_dp_sts            o_sts,
    output logic               o_valid,
    output t_rsp               o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    logic signed [31:0] r_key, n_key;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic               r_valid, n_valid;
    t_rsp               r_rsp, n_rsp;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    // Map a position in sorted order to its slot in the ring.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        n_key     = r_key;
        n_idx     = r_idx;
        n_head    = r_head;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_key;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (i_cmd.op)
            DP_REJECT: begin
                n_valid             = 1'b1;
                n_rsp.status        = i_cmd.reject_status;
                n_rsp.removed_value = '0;
                n_rsp.fill_count    = 5'(r_count);
            end
            DP_ENQ_FIRST: begin
                mem_we              = 1'b1;
                mem_waddr           = r_head;
                mem_wdata           = i_value;
                n_count             = r_count + CW'(1);
                n_valid             = 1'b1;
                n_rsp.status        = ST_DONE;
                n_rsp.removed_value = '0;
                n_rsp.fill_count    = 5'(n_count);
            end
            DP_SCAN_START: begin
                n_key     = i_value;
                n_idx     = AW'(r_count - CW'(1));
                mem_re    = 1'b1;
                mem_raddr = phys(r_head, n_idx);
            end
            DP_SHIFT: begin
                // move the larger key up; at index zero the decrement wraps so
                // that the following place lands on position zero
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, AW'(r_idx + AW'(1)));
                mem_wdata = r_rd_data;
                n_idx     = r_idx - AW'(1);
                mem_re    = 1'b1;
                mem_raddr = phys(r_head, n_idx);
            end
            DP_PLACE: begin
                mem_we              = 1'b1;
                mem_waddr           = phys(r_head, AW'(r_idx + AW'(1)));
                mem_wdata           = r_key;
                n_count             = r_count + CW'(1);
                n_valid             = 1'b1;
                n_rsp.status        = ST_DONE;
                n_rsp.removed_value = '0;
                n_rsp.fill_count    = 5'(n_count);
            end
            DP_DEQ_READ: begin
                mem_re    = 1'b1;
                mem_raddr = r_head;
            end
            DP_DEQ_POP: begin
                n_head              = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                n_count             = r_count - CW'(1);
                n_valid             = 1'b1;
                n_rsp.status        = ST_DONE;
                n_rsp.removed_value = r_rd_data;
                n_rsp.fill_count    = 5'(n_count);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_key <= n_key;
        r_idx <= n_idx;
        r_rsp <= n_rsp;
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.greater  = (r_rd_data > r_key);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_valid        = r_valid;
    assign o_rsp          = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(DEPTH - 1))
        else $error("head pointer out of range");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == DP_DEQ_POP |=> r_count == $past(r_count) - CW'(1))
        else $error("dequeue did not drop the count");

    a_empty_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_rsp.status == ST_EMPTY |->
            r_rsp.removed_value == '0 && r_rsp.fill_count == 5'd0)
        else $error("empty reject carries data");

    a_full_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_rsp.status == ST_FULL |-> r_rsp.fill_count == 5'(DEPTH))
        else $error("full reject with wrong count");

endmodule

FILE: rtl/sorted_priority_queue.sv
// Sorted minimum priority queue, top level: one request per start pulse, one
// response strobed on o_valid for a single cycle; the receiver cannot stall it.
// Rejects (dequeue on empty, enqueue on full) and an enqueue into an empty
// queue are done in the idle state; a dequeue reads the head, then pops it; an
// enqueue shifts up every stored key greater than the new key, because the key
// memory has one read and one write port and the insert walks down from the
// tail one entry per cycle. The response appears in the cycle after the last
// command. Busy is registered: it rises once a longer request is accepted and
// falls as the response appears, so a new request may be accepted in that cycle.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_req.opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_req.value),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule
